/* hdl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, action codes and default sizes for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEFAULT       = 1024;
    localparam int VALUE_WIDTH_DEFAULT = 17;
    localparam int COUNT_WIDTH_DEFAULT = $clog2(DEPTH_DEFAULT + 1);
    localparam int ACTION_WIDTH        = 3;

    localparam logic [ACTION_WIDTH-1:0] ACT_QUERY      = 3'd0;
    localparam logic [ACTION_WIDTH-1:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [ACTION_WIDTH-1:0] ACT_PUSH_BACK  = 3'd2;
    localparam logic [ACTION_WIDTH-1:0] ACT_POP_FRONT  = 3'd3;
    localparam logic [ACTION_WIDTH-1:0] ACT_POP_BACK   = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL_FRONT,
        ST_FILL_BACK
    } deq_state_t;

    typedef enum logic [2:0] {
        OP_QUERY,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK
    } deq_op_t;

    typedef struct packed {
        logic    exec;        // transaction taken this cycle
        deq_op_t op;          // effective operation (failed ones become query)
        logic    pop_ok;
        logic    overflow;
        logic    fetch;       // pop needs the new end entry from the RAM
        logic    fill_front;  // RAM data is the new front value
        logic    fill_back;   // RAM data is the new back value
        logic    out_load;    // result register becomes valid
    } deq_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic single;
        logic out_valid;
    } deq_status_t;

endpackage

/* hdl/deq_item_if.sv */
// ----------------------------------------------------------------------------
// deq_item_if
// Input channel: one deque action per transaction.
// ----------------------------------------------------------------------------
interface deq_item_if #(
    parameter int VALUE_WIDTH = deq_pkg::VALUE_WIDTH_DEFAULT
) ();

    logic                              valid;
    logic                              ready;
    logic [deq_pkg::ACTION_WIDTH-1:0]  action;
    logic [VALUE_WIDTH-1:0]            push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink   (input valid, input action, input push_value, output ready);

endinterface

/* hdl/deq_result_if.sv */
// ----------------------------------------------------------------------------
// deq_result_if
// Output channel: one result per accepted action.
// ----------------------------------------------------------------------------
interface deq_result_if #(
    parameter int VALUE_WIDTH = deq_pkg::VALUE_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH = deq_pkg::COUNT_WIDTH_DEFAULT
) ();

    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] popped_value;
    logic                   pop_ok;
    logic                   overflow;
    logic [COUNT_WIDTH-1:0] entry_count;
    logic                   is_empty;
    logic [VALUE_WIDTH-1:0] front_value;
    logic [VALUE_WIDTH-1:0] back_value;

    modport source (
        output valid, output popped_value, output pop_ok, output overflow,
        output entry_count, output is_empty, output front_value, output back_value,
        input  ready
    );
    modport sink (
        input  valid, input popped_value, input pop_ok, input overflow,
        input  entry_count, input is_empty, input front_value, input back_value,
        output ready
    );

endinterface

/* hdl/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// Result: valid in the cycle after acceptance, except for a pop that leaves
//   entries behind: it first reads the new end value from the entry RAM (registered read, fill state).
// Throughput: one transaction per cycle while the result is not stalled; a pop
//   that reads the RAM blocks new transactions until its fill state is done.
// Reset: pointers, count and cached end values clear; deque is empty at once,
//   entry RAM is not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH       = deq_pkg::DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = deq_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    deq_item_if.sink      item,
    deq_result_if.source  result
);

    deq_pkg::deq_cmd_t    cmd;
    deq_pkg::deq_status_t status;

    deq_ctrl u_deq_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .action    (item.action),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    deq_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_deq_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .push_value   (item.push_value),
        .out_ready    (result.ready),
        .out_valid    (result.valid),
        .popped_value (result.popped_value),
        .pop_ok       (result.pop_ok),
        .overflow     (result.overflow),
        .entry_count  (result.entry_count),
        .is_empty     (result.is_empty),
        .front_value  (result.front_value),
        .back_value   (result.back_value)
    );

endmodule

/* hdl/deq_ram.sv */
// ----------------------------------------------------------------------------
// deq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = deq_pkg::VALUE_WIDTH_DEFAULT,
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/deq_ctrl.sv */
// ----------------------------------------------------------------------------
// deq_ctrl
// Controller: decodes actions, sequences RAM fetches after pops.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [deq_pkg::ACTION_WIDTH-1:0] action,
    input  logic                             out_ready,
    input  deq_pkg::deq_status_t             status,
    output deq_pkg::deq_cmd_t                cmd
);

    deq_pkg::deq_state_t state_reg;
    deq_pkg::deq_state_t state_next;

    deq_pkg::deq_op_t dec_op;
    logic             dec_pop_ok;
    logic             dec_overflow;
    logic             dec_fetch;
    logic             accept;

    // controller is idle and the result register is free, or is being drained this cycle
    assign in_ready = (state_reg == deq_pkg::ST_IDLE) && (!status.out_valid || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        dec_op       = deq_pkg::OP_QUERY;
        dec_pop_ok   = 1'b0;
        dec_overflow = 1'b0;
        dec_fetch    = 1'b0;
        case (action)
            deq_pkg::ACT_PUSH_FRONT:
            begin
                if (status.full)
                    dec_overflow = 1'b1;
                else
                    dec_op = deq_pkg::OP_PUSH_FRONT;
            end
            deq_pkg::ACT_PUSH_BACK:
            begin
                if (status.full)
                    dec_overflow = 1'b1;
                else
                    dec_op = deq_pkg::OP_PUSH_BACK;
            end
            deq_pkg::ACT_POP_FRONT:
            begin
                if (!status.empty)
                begin
                    dec_op     = deq_pkg::OP_POP_FRONT;
                    dec_pop_ok = 1'b1;
                    dec_fetch  = !status.single;
                end
            end
            deq_pkg::ACT_POP_BACK:
            begin
                if (!status.empty)
                begin
                    dec_op     = deq_pkg::OP_POP_BACK;
                    dec_pop_ok = 1'b1;
                    dec_fetch  = !status.single;
                end
            end
            default:
            begin
                dec_op = deq_pkg::OP_QUERY;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            deq_pkg::ST_IDLE:
            begin
                if (accept && dec_fetch)
                begin
                    if (dec_op == deq_pkg::OP_POP_FRONT)
                        state_next = deq_pkg::ST_FILL_FRONT;
                    else
                        state_next = deq_pkg::ST_FILL_BACK;
                end
            end
            deq_pkg::ST_FILL_FRONT: state_next = deq_pkg::ST_IDLE;
            deq_pkg::ST_FILL_BACK:  state_next = deq_pkg::ST_IDLE;
            default:                state_next = deq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.exec       = accept;
        cmd.op         = dec_op;
        cmd.pop_ok     = dec_pop_ok;
        cmd.overflow   = dec_overflow;
        cmd.fetch      = accept && dec_fetch;
        cmd.fill_front = 1'b0;
        cmd.fill_back  = 1'b0;
        cmd.out_load   = 1'b0;
        case (state_reg)
            deq_pkg::ST_IDLE:
            begin
                cmd.out_load = accept && !dec_fetch;
            end
            deq_pkg::ST_FILL_FRONT:
            begin
                cmd.fill_front = 1'b1;
                cmd.out_load   = 1'b1;
            end
            deq_pkg::ST_FILL_BACK:
            begin
                cmd.fill_back = 1'b1;
                cmd.out_load  = 1'b1;
            end
            default:
            begin
                cmd.out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= deq_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* hdl/deq_datapath.sv */
// ----------------------------------------------------------------------------
// deq_datapath
// Pointers, count, cached end values, entry RAM and result register.
// ----------------------------------------------------------------------------
module deq_datapath #(
    parameter int DEPTH       = deq_pkg::DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = deq_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  deq_pkg::deq_cmd_t                cmd,
    output deq_pkg::deq_status_t             status,
    input  logic [VALUE_WIDTH-1:0]           push_value,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [VALUE_WIDTH-1:0]           popped_value,
    output logic                             pop_ok,
    output logic                             overflow,
    output logic [$clog2(DEPTH+1)-1:0]       entry_count,
    output logic                             is_empty,
    output logic [VALUE_WIDTH-1:0]           front_value,
    output logic [VALUE_WIDTH-1:0]           back_value
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_LAST : p - 1'b1;
    endfunction

    logic [PTR_W-1:0]       front_ptr_reg, front_ptr_next;
    logic [PTR_W-1:0]       back_ptr_reg, back_ptr_next;   // one past the back entry
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [VALUE_WIDTH-1:0] front_val_reg, front_val_next;
    logic [VALUE_WIDTH-1:0] back_val_reg, back_val_next;

    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] out_popped_reg, out_popped_next;
    logic                   out_pop_ok_reg, out_pop_ok_next;
    logic                   out_overflow_reg, out_overflow_next;
    logic [CNT_W-1:0]       out_count_reg, out_count_next;
    logic                   out_empty_reg, out_empty_next;
    logic [VALUE_WIDTH-1:0] out_front_reg, out_front_next;
    logic [VALUE_WIDTH-1:0] out_back_reg, out_back_next;

    logic                   ram_we;
    logic [PTR_W-1:0]       ram_waddr;
    logic                   ram_re;
    logic [PTR_W-1:0]       ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;
    logic [VALUE_WIDTH-1:0] popped;

    deq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_deq_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (push_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign status.empty     = (count_reg == '0);
    assign status.full      = (count_reg == CNT_W'(DEPTH));
    assign status.single    = (count_reg == CNT_W'(1));
    assign status.out_valid = out_valid_reg;

    always_comb
    begin
        front_ptr_next = front_ptr_reg;
        back_ptr_next  = back_ptr_reg;
        count_next     = count_reg;
        front_val_next = front_val_reg;
        back_val_next  = back_val_reg;
        ram_we         = 1'b0;
        ram_waddr      = back_ptr_reg;
        ram_re         = 1'b0;
        ram_raddr      = ptr_inc(front_ptr_reg);
        popped         = '0;

        if (cmd.exec)
        begin
            case (cmd.op)
                deq_pkg::OP_PUSH_FRONT:
                begin
                    front_ptr_next = ptr_dec(front_ptr_reg);
                    ram_we         = 1'b1;
                    ram_waddr      = ptr_dec(front_ptr_reg);
                    front_val_next = push_value;
                    if (status.empty)
                        back_val_next = push_value;
                    count_next = count_reg + 1'b1;
                end
                deq_pkg::OP_PUSH_BACK:
                begin
                    back_ptr_next = ptr_inc(back_ptr_reg);
                    ram_we        = 1'b1;
                    ram_waddr     = back_ptr_reg;
                    back_val_next = push_value;
                    if (status.empty)
                        front_val_next = push_value;
                    count_next = count_reg + 1'b1;
                end
                deq_pkg::OP_POP_FRONT:
                begin
                    popped         = front_val_reg;
                    front_ptr_next = ptr_inc(front_ptr_reg);
                    count_next     = count_reg - 1'b1;
                    ram_re         = cmd.fetch;
                    ram_raddr      = ptr_inc(front_ptr_reg);
                    if (status.single)
                    begin
                        front_val_next = '0;
                        back_val_next  = '0;
                    end
                end
                deq_pkg::OP_POP_BACK:
                begin
                    popped        = back_val_reg;
                    back_ptr_next = ptr_dec(back_ptr_reg);
                    count_next    = count_reg - 1'b1;
                    ram_re        = cmd.fetch;
                    // new back entry sits two below the old end pointer
                    ram_raddr     = ptr_dec(ptr_dec(back_ptr_reg));
                    if (status.single)
                    begin
                        front_val_next = '0;
                        back_val_next  = '0;
                    end
                end
                default:
                begin
                    popped = '0;
                end
            endcase
        end

        if (cmd.fill_front)
            front_val_next = ram_rdata;
        if (cmd.fill_back)
            back_val_next = ram_rdata;
    end

    always_comb
    begin
        out_popped_next   = out_popped_reg;
        out_pop_ok_next   = out_pop_ok_reg;
        out_overflow_next = out_overflow_reg;
        out_count_next    = out_count_reg;
        out_empty_next    = out_empty_reg;
        out_front_next    = out_front_reg;
        out_back_next     = out_back_reg;
        if (cmd.exec)
        begin
            out_popped_next   = popped;
            out_pop_ok_next   = cmd.pop_ok;
            out_overflow_next = cmd.overflow;
            out_count_next    = count_next;
            out_empty_next    = (count_next == '0);
            out_front_next    = front_val_next;
            out_back_next     = back_val_next;
        end
        if (cmd.fill_front)
            out_front_next = ram_rdata;
        if (cmd.fill_back)
            out_back_next = ram_rdata;
        out_valid_next = cmd.out_load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_ptr_reg <= '0;
            back_ptr_reg  <= '0;
            count_reg     <= '0;
            front_val_reg <= '0;
            back_val_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_ptr_reg <= front_ptr_next;
            back_ptr_reg  <= back_ptr_next;
            count_reg     <= count_next;
            front_val_reg <= front_val_next;
            back_val_reg  <= back_val_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_popped_reg   <= out_popped_next;
        out_pop_ok_reg   <= out_pop_ok_next;
        out_overflow_reg <= out_overflow_next;
        out_count_reg    <= out_count_next;
        out_empty_reg    <= out_empty_next;
        out_front_reg    <= out_front_next;
        out_back_reg     <= out_back_next;
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = out_popped_reg;
    assign pop_ok       = out_pop_ok_reg;
    assign overflow     = out_overflow_reg;
    assign entry_count  = out_count_reg;
    assign is_empty     = out_empty_reg;
    assign front_value  = out_front_reg;
    assign back_value   = out_back_reg;

endmodule

/* hdl/deq_checker.sv */
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks on the result channel of the double-ended queue.
// ----------------------------------------------------------------------------
module deq_checker #(
    parameter int DEPTH       = deq_pkg::DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = deq_pkg::VALUE_WIDTH_DEFAULT
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [VALUE_WIDTH-1:0]     popped_value,
    input logic                       pop_ok,
    input logic                       overflow,
    input logic [$clog2(DEPTH+1)-1:0] entry_count,
    input logic                       is_empty,
    input logic [VALUE_WIDTH-1:0]     front_value,
    input logic [VALUE_WIDTH-1:0]     back_value
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(popped_value) && $stable(pop_ok)
            && $stable(overflow) && $stable(entry_count) && $stable(is_empty)
            && $stable(front_value) && $stable(back_value))
        else $error("result changed while stalled");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> is_empty == (entry_count == '0))
        else $error("empty flag disagrees with count");

    a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> front_value == '0 && back_value == '0)
        else $error("end values nonzero on empty deque");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pop_ok |-> popped_value == '0)
        else $error("popped value without a successful pop");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(pop_ok && overflow) && entry_count <= CNT_W'(DEPTH))
        else $error("count out of range or conflicting flags");

endmodule

bind double_ended_queue deq_checker #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_deq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .popped_value (result.popped_value),
    .pop_ok       (result.pop_ok),
    .overflow     (result.overflow),
    .entry_count  (result.entry_count),
    .is_empty     (result.is_empty),
    .front_value  (result.front_value),
    .back_value   (result.back_value)
);
